// File: hw/rtl/wsd_pkg.sv
// websocket deframer package: phase and status codes, result struct, constants
// used by wsd_in_reg, wsd_parser and websocket_frame_deframer; no dependencies
`default_nettype none

package wsd_pkg;

  localparam int unsigned MAX_PAYLOAD_RESET = 4096;
  localparam int unsigned LEN_W = 16;

  localparam logic [6:0] LEN7_MASK  = 7'h7f;
  localparam logic [6:0] LEN7_EXT16 = 7'd126;
  localparam logic [6:0] LEN7_EXT64 = 7'd127;
  localparam logic [6:0] LEN_MIN    = 7'd4;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXT0    = 3'd2,
    PH_EXT1    = 3'd3,
    PH_KEY     = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_DEAD    = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NOT_FINAL = 3'd1,
    ST_UNMASKED  = 3'd2,
    ST_LEN64     = 3'd3,
    ST_SHORT     = 3'd4,
    ST_BAD_LEN   = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] payload_byte;
    logic       frame_first;
    logic       frame_last;
    status_t    status;
  } res_t;

endpackage

`default_nettype wire

// File: hw/rtl/wsd_in_reg.sv
// input register stage of the websocket deframer
// depends on wsd_pkg
`default_nettype none

module wsd_in_reg
  import wsd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  input  wire logic       take,
  output logic            q_valid,
  output logic [7:0]      q_byte
);

  // refill in the same cycle the held byte moves on
  assign in_ready = !q_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      q_valid <= 1'b0;
    end else if (in_ready) begin
      q_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      q_byte <= rx_byte;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/wsd_parser.sv
// frame header state machine, mask key store and payload unmasking
// depends on wsd_pkg
`default_nettype none

module wsd_parser
  import wsd_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             step,
  input  wire logic [7:0]       b,
  input  wire logic [LEN_W-1:0] max_payload,
  output logic                  res_valid,
  output res_t                  res
);

  phase_t           phase, phase_next;
  logic [LEN_W-1:0] frame_len;
  logic [LEN_W-1:0] idx;
  logic [7:0]       key [4];
  logic [23:0]      emb;

  logic             err;
  status_t          err_code;
  logic [7:0]       v;
  logic [LEN_W-1:0] idx_inc;
  logic [LEN_W-1:0] ext_len;
  logic             last;

  assign v       = b ^ key[idx[1:0]];
  assign idx_inc = idx + LEN_W'(1);
  assign ext_len = {frame_len[15:8], b};
  assign last    = (idx_inc == frame_len);

  // header and embedded length checks
  always_comb begin
    err      = 1'b0;
    err_code = ST_OK;
    unique case (phase)
      PH_HDR0: begin
        if (!b[7]) begin
          err      = 1'b1;
          err_code = ST_NOT_FINAL;
        end
      end
      PH_HDR1: begin
        if (!b[7]) begin
          err      = 1'b1;
          err_code = ST_UNMASKED;
        end else if ((b[6:0] & LEN7_MASK) == LEN7_EXT64) begin
          err      = 1'b1;
          err_code = ST_LEN64;
        end else if (b[6:0] != LEN7_EXT16 && b[6:0] < LEN_MIN) begin
          err      = 1'b1;
          err_code = ST_SHORT;
        end
      end
      PH_EXT1: begin
        if (ext_len < LEN_W'(LEN_MIN)) begin
          err      = 1'b1;
          err_code = ST_SHORT;
        end
      end
      PH_PAYLOAD: begin
        if (idx == LEN_W'(3) && (emb[23:8] != 16'd0 || {emb[7:0], v} != frame_len
            || frame_len > max_payload)) begin
          err      = 1'b1;
          err_code = ST_BAD_LEN;
        end
      end
      default: begin
      end
    endcase
  end

  // next phase
  always_comb begin
    phase_next = phase;
    if (err) begin
      phase_next = PH_DEAD;
    end else begin
      unique case (phase)
        PH_HDR0:    phase_next = PH_HDR1;
        PH_HDR1:    phase_next = (b[6:0] == LEN7_EXT16) ? PH_EXT0 : PH_KEY;
        PH_EXT0:    phase_next = PH_EXT1;
        PH_EXT1:    phase_next = PH_KEY;
        PH_KEY:     phase_next = (idx[1:0] == 2'd3) ? PH_PAYLOAD : PH_KEY;
        PH_PAYLOAD: phase_next = last ? PH_HDR0 : PH_PAYLOAD;
        PH_DEAD:    phase_next = PH_DEAD;
        default:    phase_next = PH_DEAD;
      endcase
    end
  end

  // result of this byte
  always_comb begin
    res_valid        = 1'b0;
    res.payload_byte = 8'd0;
    res.frame_first  = 1'b0;
    res.frame_last   = 1'b0;
    res.status       = err_code;
    if (err) begin
      res_valid = 1'b1;
    end else if (phase == PH_PAYLOAD) begin
      res_valid        = 1'b1;
      res.payload_byte = v;
      res.frame_first  = (idx == '0);
      res.frame_last   = last;
      res.status       = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_HDR0;
    end else if (step) begin
      phase <= phase_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_len <= '0;
      idx       <= '0;
      emb       <= '0;
    end else if (step && !err) begin
      unique case (phase)
        PH_HDR1: begin
          frame_len <= LEN_W'(b[6:0]);
          idx       <= '0;
        end
        PH_EXT0: frame_len <= {b, 8'd0};
        PH_EXT1: begin
          frame_len <= ext_len;
          idx       <= '0;
        end
        PH_KEY: begin
          idx <= (idx[1:0] == 2'd3) ? '0 : idx_inc;
          emb <= '0;
        end
        PH_PAYLOAD: begin
          idx <= last ? '0 : idx_inc;
          if (idx < LEN_W'(3)) begin
            emb <= {emb[15:0], v};
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key[0] <= 8'd0;
      key[1] <= 8'd0;
      key[2] <= 8'd0;
      key[3] <= 8'd0;
    end else if (step && phase == PH_KEY) begin
      key[idx[1:0]] <= b;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/websocket_frame_deframer.sv
// websocket client-to-server deframer, top level with result register
// depends on wsd_pkg, wsd_in_reg, wsd_parser
//
// usage
// - input channel: in_valid / in_ready with rx_byte, one stream byte per transfer
// - output channel: out_valid / out_ready with payload_byte, frame_first,
//   frame_last and status; one result per payload byte, none for header,
//   extended length or mask key bytes
// - cfg_wr_en / cfg_wr_data write max_payload at once; write only while idle
// - a transferred byte sits in the input register, and the parser loads its
//   result from there into the result register
// - throughput: one byte per cycle unless stalled; the parser state update is a
//   single pass of short logic between the input and the result register
// - a held result stalls the parser: a byte moves on only when the result
//   register is empty or being drained in the same cycle
// - when the receiver stalls, one byte waits in the input register and then
//   in_ready drops
// - any header or length failure gives one error result (status nonzero,
//   payload fields zero); every later byte is taken and dropped until reset
// - synchronous reset: parser waits for the first header byte, mask key and
//   lengths clear, max_payload returns to 4096, both registers empty
`default_nettype none

module websocket_frame_deframer
  import wsd_pkg::*;
#(
  parameter int unsigned MaxPayloadReset = MAX_PAYLOAD_RESET
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire logic [7:0]       rx_byte,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic [7:0]            payload_byte,
  output logic                  frame_first,
  output logic                  frame_last,
  output logic [2:0]            status,
  input  wire logic             cfg_wr_en,
  input  wire logic [LEN_W-1:0] cfg_wr_data
);

  logic [LEN_W-1:0] max_payload;
  logic             q_valid;
  logic [7:0]       q_byte;
  logic             step;
  logic             res_valid;
  res_t             res;
  res_t             out_q;

  // byte leaves the input register when the result slot is free or draining
  assign step = q_valid && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload <= LEN_W'(MaxPayloadReset);
    end else if (cfg_wr_en) begin
      max_payload <= cfg_wr_data;
    end
  end

  wsd_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .rx_byte  (rx_byte),
    .take     (step),
    .q_valid  (q_valid),
    .q_byte   (q_byte)
  );

  wsd_parser u_parser (
    .clk         (clk),
    .rst         (rst),
    .step        (step),
    .b           (q_byte),
    .max_payload (max_payload),
    .res_valid   (res_valid),
    .res         (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step && res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign payload_byte = out_q.payload_byte;
  assign frame_first  = out_q.frame_first;
  assign frame_last   = out_q.frame_last;
  assign status       = out_q.status;

endmodule

`default_nettype wire

// File: dv/tb_websocket_frame_deframer.sv
`timescale 1ns / 1ps
// self-checking testbench for websocket_frame_deframer: framed byte stream in bursts,
// in-order check of every result against a byte-level deframer predictor
// depends on wsd_pkg and the websocket_frame_deframer rtl

module tb_websocket_frame_deframer;
  import wsd_pkg::*;

  // idle cycles before a register write, covers input reg plus result reg
  localparam int unsigned SETTLE_CYCLES = 6;
  // watchdog: cycles without any transfer, and an absolute ceiling
  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned RUN_LIMIT     = 1000000;
  localparam int unsigned MAX_PRINTS    = 200;
  // longest frame the random part builds, keeps the run short
  localparam int unsigned RAND_LEN_CAP  = 32;

  // the block dies on its first error, so only one error scenario fits in a run
  typedef enum int {
    ERR_NOT_FINAL,
    ERR_UNMASKED,
    ERR_LEN64,
    ERR_SHORT7,
    ERR_SHORT16,
    ERR_MISMATCH,
    ERR_OVER_LIMIT
  } err_case_t;

  // receiver back-pressure patterns
  typedef enum logic [1:0] {
    RX_ALWAYS,
    RX_COIN,
    RX_EVERY4,
    RX_SPARSE
  } rx_mode_t;

  logic             clk         = 1'b0;
  logic             rst         = 1'b1;
  logic             in_valid    = 1'b0;
  logic             in_ready;
  logic [7:0]       rx_byte     = 8'h00;
  logic             out_valid;
  logic             out_ready   = 1'b0;
  logic [7:0]       payload_byte;
  logic             frame_first;
  logic             frame_last;
  logic [2:0]       status;
  logic             cfg_wr_en   = 1'b0;
  logic [LEN_W-1:0] cfg_wr_data = '0;

  websocket_frame_deframer u_dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .rx_byte      (rx_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .payload_byte (payload_byte),
    .frame_first  (frame_first),
    .frame_last   (frame_last),
    .status       (status),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // deframer predictor state, its own copy of the max_payload register
  // ---------------------------------------------------------------------------
  phase_t      dfr_phase;
  logic [15:0] dfr_frame_len;
  logic [7:0]  dfr_key [4];
  int unsigned dfr_idx;
  logic [31:0] dfr_emb_len;
  logic [15:0] dfr_max_payload;

  logic [7:0]  pending_bytes [$];     // stream bytes waiting for the driver
  res_t        expected_results [$];  // predicted results, oldest first
  int unsigned fail_count  = 0;
  int unsigned idle_cycles = 0;
  int unsigned cycle_count = 0;

  task automatic report_failure(input string msg);
    if (fail_count < MAX_PRINTS) $display("error @%0t: %s", $realtime, msg);
    fail_count++;
  endtask

  // append a stream byte for the driver
  task automatic enqueue_byte(input logic [7:0] b);
    pending_bytes.insert(pending_bytes.size(), b);
  endtask

  // append a predicted result
  task automatic enqueue_result(input res_t r);
    expected_results.insert(expected_results.size(), r);
  endtask

  // error result: payload fields zero, then the block ignores everything
  task automatic expect_error(input status_t code);
    res_t res;
    res.payload_byte = 8'h00;
    res.frame_first  = 1'b0;
    res.frame_last   = 1'b0;
    res.status       = code;
    enqueue_result(res);
    dfr_phase = PH_DEAD;
  endtask

  // advance the predictor by one transferred stream byte
  task automatic deframe_byte(input logic [7:0] b);
    logic [6:0] len7;
    logic [7:0] plain;
    res_t       res;
    len7 = b[6:0] & LEN7_MASK;
    case (dfr_phase)
      PH_HDR0: begin
        // opcode and rsv bits are don't-care, only fin matters
        if (!b[7]) expect_error(ST_NOT_FINAL);
        else dfr_phase = PH_HDR1;
      end
      PH_HDR1: begin
        if (!b[7]) expect_error(ST_UNMASKED);
        else if (len7 == LEN7_EXT64) expect_error(ST_LEN64);
        else if (len7 == LEN7_EXT16) dfr_phase = PH_EXT0;
        else if (len7 < LEN_MIN) expect_error(ST_SHORT);
        else begin
          dfr_frame_len = {9'd0, len7};
          dfr_idx       = 0;
          dfr_phase     = PH_KEY;
        end
      end
      PH_EXT0: begin
        dfr_frame_len = {b, 8'h00};
        dfr_phase     = PH_EXT1;
      end
      PH_EXT1: begin
        dfr_frame_len[7:0] = b;
        if (dfr_frame_len < {9'd0, LEN_MIN}) expect_error(ST_SHORT);
        else begin
          dfr_idx   = 0;
          dfr_phase = PH_KEY;
        end
      end
      PH_KEY: begin
        dfr_key[dfr_idx % 4] = b;
        dfr_idx++;
        if (dfr_idx >= 4) begin
          dfr_idx     = 0;
          dfr_emb_len = '0;
          dfr_phase   = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        plain = b ^ dfr_key[dfr_idx % 4];
        if (dfr_idx < 4) dfr_emb_len = {dfr_emb_len[23:0], plain};
        // embedded length checked on the fourth byte, which the error replaces
        if (dfr_idx == 3 && (dfr_emb_len != {16'd0, dfr_frame_len} ||
                             dfr_emb_len > {16'd0, dfr_max_payload})) begin
          expect_error(ST_BAD_LEN);
        end else begin
          res.payload_byte = plain;
          res.frame_first  = (dfr_idx == 0);
          res.frame_last   = (dfr_idx + 1 == dfr_frame_len);
          res.status       = ST_OK;
          enqueue_result(res);
          dfr_idx++;
          if (dfr_idx >= dfr_frame_len) begin
            dfr_idx   = 0;
            dfr_phase = PH_HDR0;
          end
        end
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // stimulus builders
  // ---------------------------------------------------------------------------

  // one masked client frame; the first four plain payload bytes carry emb_len
  task automatic queue_frame(input logic [7:0] hdr0, input int unsigned len,
                             input bit use_ext, input logic [31:0] key_word,
                             input logic [31:0] emb_len);
    logic [7:0] plain;
    enqueue_byte(hdr0);
    if (use_ext) begin
      enqueue_byte({1'b1, LEN7_EXT16});
      enqueue_byte(8'(len >> 8));
      enqueue_byte(8'(len));
    end else begin
      enqueue_byte({1'b1, 7'(len)});
    end
    for (int k = 0; k < 4; k++) enqueue_byte(key_word[8*(3-k) +: 8]);
    for (int i = 0; i < int'(len); i++) begin
      plain = (i < 4) ? emb_len[8*(3-i) +: 8] : 8'($urandom);
      enqueue_byte(plain ^ key_word[8*(3-(i%4)) +: 8]);
    end
  endtask

  // well-formed frames with random header bits, key, length and content
  task automatic queue_random_frames(input int unsigned n_bytes,
                                     input int unsigned max_len);
    int unsigned done_bytes;
    int unsigned len;
    int unsigned cap;
    bit          use_ext;
    done_bytes = 0;
    cap = (max_len < RAND_LEN_CAP) ? max_len : RAND_LEN_CAP;
    while (done_bytes < n_bytes) begin
      use_ext = ($urandom_range(0, 3) == 0);
      if (use_ext) len = $urandom_range(4, cap);
      else if ($urandom_range(0, 15) == 0) len = (cap < 125) ? cap : 125;
      else len = $urandom_range(4, (cap < 125) ? cap : 125);
      queue_frame({1'b1, 7'($urandom)}, len, use_ext, $urandom, len);
      done_bytes += len + (use_ext ? 8 : 6);
    end
  endtask

  // wait until the stream is drained and every result has come out
  task automatic settle();
    while (pending_bytes.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_max_payload(input logic [15:0] value);
    @(posedge clk);
    cfg_wr_en       <= 1'b1;
    cfg_wr_data     <= value;
    dfr_max_payload  = value;
    @(posedge clk);
    cfg_wr_en       <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // input driver: bursts of random length with random gaps in between
  // ---------------------------------------------------------------------------
  int unsigned burst_left;
  int unsigned gap_left;

  always @(posedge clk) begin
    if (rst) begin
      in_valid   <= 1'b0;
      rx_byte    <= 8'h00;
      burst_left <= 1;
      gap_left   <= 0;
    end else begin
      // transfer happened at this edge: feed the predictor
      if (in_valid && in_ready) deframe_byte(rx_byte);
      // only touch valid/payload when the slot is free
      if (!in_valid || in_ready) begin
        if (gap_left != 0) begin
          gap_left <= gap_left - 1;
          in_valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          in_valid <= 1'b1;
          rx_byte  <= pending_bytes[0];
          pending_bytes.delete(0);
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 48);
            // a quarter of bursts run straight into the next one
            gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result monitor and receiver back-pressure
  // ---------------------------------------------------------------------------
  rx_mode_t    rx_mode;
  int unsigned rx_mode_left;
  res_t        want;

  always @(posedge clk) begin
    if (rst) begin
      out_ready    <= 1'b0;
      rx_mode      <= RX_ALWAYS;
      rx_mode_left <= 100;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          report_failure($sformatf("unexpected result byte %02h status %0d",
                                   payload_byte, status));
        end else begin
          want = expected_results[0];
          expected_results.delete(0);
          if (payload_byte !== want.payload_byte)
            report_failure($sformatf("payload_byte got %02h want %02h",
                                     payload_byte, want.payload_byte));
          if (frame_first !== want.frame_first)
            report_failure($sformatf("frame_first got %b want %b",
                                     frame_first, want.frame_first));
          if (frame_last !== want.frame_last)
            report_failure($sformatf("frame_last got %b want %b",
                                     frame_last, want.frame_last));
          if (status !== want.status)
            report_failure($sformatf("status got %0d want %0d",
                                     status, want.status));
        end
      end
      // switch stall pattern now and then
      if (rx_mode_left == 0) begin
        rx_mode      <= rx_mode_t'($urandom_range(0, 3));
        rx_mode_left <= $urandom_range(20, 150);
      end else begin
        rx_mode_left <= rx_mode_left - 1;
      end
      case (rx_mode)
        RX_ALWAYS: out_ready <= 1'b1;
        RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
        RX_EVERY4: out_ready <= (cycle_count % 4 == 0);
        default:   out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < STALL_LIMIT && cycle_count < RUN_LIMIT) @(negedge clk);
    $display("watchdog: no progress, %0d idle cycles", idle_cycles);
    $display("*** FAILED ***");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------
  initial begin : main_seq
    err_case_t   err_case;
    int unsigned len;
    logic [15:0] limit;

    dfr_phase       = PH_HDR0;
    dfr_frame_len   = '0;
    dfr_idx         = 0;
    dfr_emb_len     = '0;
    dfr_max_payload = 16'(MAX_PAYLOAD_RESET);
    for (int k = 0; k < 4; k++) dfr_key[k] = 8'h00;

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: shortest 7-bit frame with zero key and clear header bits,
    // then a short 16-bit length frame with all header bits and an all-ones key
    queue_frame(8'h80, 4, 1'b0, 32'h0000_0000, 32'd4);
    queue_frame(8'hff, 5, 1'b1, 32'hffff_ffff, 32'd5);

    // reset value of max_payload
    queue_random_frames(40, MAX_PAYLOAD_RESET);
    settle();

    // widest limit, longest 7-bit length and an extended frame past 255 bytes
    write_max_payload(16'hffff);
    queue_frame({1'b1, 7'($urandom)}, 125, 1'b0, $urandom, 32'd125);
    queue_frame({1'b1, 7'($urandom)}, 256, 1'b1, $urandom, 32'd256);
    queue_random_frames(30, 16'hffff);
    settle();

    // tightest limit: only 4-byte frames pass
    write_max_payload(16'(LEN_MIN));
    queue_random_frames(30, LEN_MIN);
    settle();

    // random limit
    limit = 16'($urandom_range(4, 65535));
    write_max_payload(limit);
    queue_random_frames(30, limit);
    settle();

    // closing: one error scenario, then trailing noise that must be dropped
    err_case = err_case_t'($urandom_range(0, 6));
    if (err_case == ERR_OVER_LIMIT) begin
      write_max_payload(16'($urandom_range(4, 40)));
    end
    queue_random_frames(20, dfr_max_payload);
    case (err_case)
      ERR_NOT_FINAL: enqueue_byte({1'b0, 7'($urandom)});
      ERR_UNMASKED: begin
        enqueue_byte({1'b1, 7'($urandom)});
        enqueue_byte({1'b0, 7'($urandom)});
      end
      ERR_LEN64: begin
        enqueue_byte({1'b1, 7'($urandom)});
        enqueue_byte({1'b1, LEN7_EXT64});
      end
      ERR_SHORT7: begin
        enqueue_byte({1'b1, 7'($urandom)});
        enqueue_byte({1'b1, 7'($urandom_range(0, 3))});
      end
      ERR_SHORT16: begin
        // extended length below the minimum, rejected on its second byte
        enqueue_byte({1'b1, 7'($urandom)});
        enqueue_byte({1'b1, LEN7_EXT16});
        enqueue_byte(8'h00);
        enqueue_byte(8'($urandom_range(0, 3)));
      end
      ERR_MISMATCH: begin
        // embedded length off by one flipped bit
        len = $urandom_range(4, 60);
        queue_frame({1'b1, 7'($urandom)}, len, 1'($urandom_range(0, 1)), $urandom,
                    len ^ (32'd1 << $urandom_range(0, 31)));
      end
      default: begin
        // embedded length matches the frame but exceeds the limit
        len = dfr_max_payload + $urandom_range(1, 50);
        queue_frame({1'b1, 7'($urandom)}, len, 1'b1, $urandom, len);
      end
    endcase
    repeat (20) enqueue_byte(8'($urandom));
    settle();

    if (expected_results.size() != 0)
      report_failure($sformatf("%0d results never arrived", expected_results.size()));
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
